// File: hw/rtl/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg
// shared types, constants and helpers of the binary to ascii converter
// ----------------------------------------------------------------------------
package b2a_pkg;

  localparam int unsigned ValueW       = 32;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned CharW        = 7;
  localparam int unsigned DigitSlots   = 10;
  localparam int unsigned BitsPerCycle = 4;
  localparam int unsigned ShiftCycles  = ValueW / BitsPerCycle;
  localparam int unsigned CntW         = $clog2(ShiftCycles);
  localparam int unsigned PtrW         = $clog2(DigitSlots);

  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;
  localparam logic [DigitW-1:0] DecimalTop  = 4'd9;

  localparam logic [CharW-1:0] CharZero   = 7'd48;
  localparam logic [CharW-1:0] CharUpperA = 7'd65;

  typedef logic [DigitW-1:0] digit_t;

  typedef struct packed {
    logic                         valid;
    digit_t [DigitSlots-1:0]      digits;
  } b2a_res_t;

  function automatic logic [CharW-1:0] digit_to_ascii(input digit_t d);
    logic [CharW-1:0] c;
    if (d <= DecimalTop) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharUpperA + CharW'(d - (DecimalTop + 4'd1));
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/b2a_if.sv
// ----------------------------------------------------------------------------
// b2a interfaces
// valid/ready channels for values in and characters out
// ----------------------------------------------------------------------------
interface b2a_in_if import b2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              radix_is_hex;

  modport source (output valid, output value, output radix_is_hex, input ready);
  modport sink   (input valid, input value, input radix_is_hex, output ready);
endinterface

interface b2a_out_if import b2a_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: hw/rtl/b2a_cell.sv
// ----------------------------------------------------------------------------
// b2a_cell
// one digit of the shift-and-correct chain, several bit steps per cycle while shift_i is set
// ----------------------------------------------------------------------------
module b2a_cell import b2a_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    shift_i,
  input  logic                    hex_i,
  input  logic [BitsPerCycle-1:0] carry_i,
  output logic [BitsPerCycle-1:0] carry_o,
  output digit_t                  digit_o
);

  digit_t digit_q, digit_d;

  always_comb begin
    digit_d = digit_q;
    for (int j = 0; j < BitsPerCycle; j++) begin
      if (!hex_i && (digit_d >= DabbleLimit)) begin
        digit_d = digit_d + DabbleAdd;
      end
      carry_o[j] = digit_d[DigitW-1];
      digit_d    = {digit_d[DigitW-2:0], carry_i[j]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (clear_i) begin
      digit_q <= '0;
    end else if (shift_i) begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

// File: hw/rtl/b2a_conv.sv
// ----------------------------------------------------------------------------
// b2a_conv
// feeds the value into the digit cell chain and holds the finished digits
// ----------------------------------------------------------------------------
module b2a_conv import b2a_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2a_in_if.sink      in_i,
  input  logic        take_i,
  output b2a_res_t    res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } conv_state_e;

  conv_state_e       state_q;
  logic [CntW-1:0]   cnt_q;
  logic [ValueW-1:0] value_q;
  logic              hex_q;
  logic              accept;
  logic              shift;

  logic [DigitSlots:0][BitsPerCycle-1:0] carry;
  digit_t [DigitSlots-1:0]                digits;

  assign in_i.ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && take_i);
  assign accept     = in_i.valid && in_i.ready;
  assign shift      = (state_q == ST_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SHIFT;
            cnt_q   <= '0;
          end
        end
        ST_SHIFT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(ShiftCycles - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take_i) begin
            state_q <= accept ? ST_SHIFT : ST_IDLE;
            cnt_q   <= '0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= in_i.value;
      hex_q   <= in_i.radix_is_hex;
    end else if (shift) begin
      value_q <= {value_q[ValueW-BitsPerCycle-1:0], {BitsPerCycle{1'b0}}};
    end
  end

  // msb first into the least significant digit
  always_comb begin
    for (int j = 0; j < BitsPerCycle; j++) begin
      carry[0][j] = value_q[ValueW-1-j];
    end
  end

  for (genvar k = 0; k < DigitSlots; k++) begin : g_cell
    b2a_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (accept),
      .shift_i (shift),
      .hex_i   (hex_q),
      .carry_i (carry[k]),
      .carry_o (carry[k+1]),
      .digit_o (digits[k])
    );
  end

  assign res_o.valid  = (state_q == ST_DONE);
  assign res_o.digits = digits;

endmodule

// File: hw/rtl/b2a_emit.sv
// ----------------------------------------------------------------------------
// b2a_emit
// drops leading zeros and sends the digits out one character at a time
// ----------------------------------------------------------------------------
module b2a_emit import b2a_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  b2a_res_t    res_i,
  output logic        take_o,
  b2a_out_if.source   out_o
);

  digit_t [DigitSlots-1:0] digits_q;
  logic [PtrW-1:0]         ptr_q;
  logic                    busy_q;
  logic                    last;

  function automatic logic [PtrW-1:0] msd_index(input digit_t [DigitSlots-1:0] d);
    logic [PtrW-1:0] idx;
    idx = '0;
    for (int k = 1; k < DigitSlots; k++) begin
      if (d[k] != '0) begin
        idx = PtrW'(k);
      end
    end
    return idx;
  endfunction

  assign last   = (ptr_q == '0);
  assign take_o = res_i.valid && (!busy_q || (last && out_o.ready));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ptr_q  <= '0;
    end else if (take_o) begin
      busy_q <= 1'b1;
      ptr_q  <= msd_index(res_i.digits);
    end else if (busy_q && out_o.ready) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        ptr_q <= ptr_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      digits_q <= res_i.digits;
    end
  end

  assign out_o.valid      = busy_q;
  assign out_o.digit_char = digit_to_ascii(digits_q[ptr_q]);
  assign out_o.last_digit = last;

endmodule

// File: hw/rtl/binary_to_ascii_dec_hex.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_dec_hex
// 32-bit unsigned value to decimal or uppercase hex ascii characters
// ----------------------------------------------------------------------------
// A value is pushed four bits per cycle through a chain of ten digit cells
// (shift-and-add-3 for decimal, plain shift for hex); the finished digits
// are then held until the output stage takes them. The output stage sends
// one character per cycle while the sink is ready, most significant first
// with leading zeros dropped, last_digit set on the final one. The next
// value converts while the previous one is still being sent.
module binary_to_ascii_dec_hex import b2a_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  b2a_in_if.sink     in_i,
  b2a_out_if.source  out_o
);

  b2a_res_t res;
  logic     take;

  b2a_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .res_o  (res)
  );

  b2a_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .take_o (take),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_take_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> res.valid)
    else $error("digits taken without a finished conversion");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !take) |=> (res.valid && $stable(res.digits)))
    else $error("finished digits changed before handoff");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !res.valid)
    else $error("result valid right after a new value was accepted");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_digit) |=> out_o.valid)
    else $error("character run broken before its last digit");
`endif

endmodule
